>>> sv/rpn_pkg.sv
// Package: word types, command and status codes, controller states.
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int DATA_W        = 32;
  localparam int STACK_DEPTH_D = 64;

  localparam logic [4:0] ACT_PUSH_INT  = 5'd0;
  localparam logic [4:0] ACT_PUSH_BOOL = 5'd1;
  localparam logic [4:0] ACT_CLEAR     = 5'd2;
  localparam logic [4:0] ACT_DROP      = 5'd3;
  localparam logic [4:0] ACT_DUP       = 5'd4;
  localparam logic [4:0] ACT_SWAP      = 5'd5;
  localparam logic [4:0] ACT_NOT       = 5'd6;
  localparam logic [4:0] ACT_ADD       = 5'd7;
  localparam logic [4:0] ACT_SUB       = 5'd8;
  localparam logic [4:0] ACT_MUL       = 5'd9;
  localparam logic [4:0] ACT_DIV       = 5'd10;
  localparam logic [4:0] ACT_MOD       = 5'd11;
  localparam logic [4:0] ACT_GT        = 5'd12;
  localparam logic [4:0] ACT_LT        = 5'd13;
  localparam logic [4:0] ACT_EQ        = 5'd14;
  localparam logic [4:0] ACT_GE        = 5'd15;
  localparam logic [4:0] ACT_LE        = 5'd16;
  localparam logic [4:0] ACT_PRINT     = 5'd17;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOT_INT  = 3'd2;
  localparam logic [2:0] ST_NOT_BOOL = 3'd3;
  localparam logic [2:0] ST_DIV_ZERO = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [4:0]               action;
    logic signed [DATA_W-1:0] int_operand;
    logic                     bool_operand;
  } in_word_t;

  typedef struct packed {
    logic [2:0]               status;
    logic                     top_valid;
    logic signed [DATA_W-1:0] top_value;
    logic                     top_is_bool;
    logic [6:0]               stack_depth;
  } out_word_t;

  typedef struct packed {
    logic              tag;
    logic [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    logic              want_mod;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH_A, S_FETCH_B, S_EXEC, S_CALC, S_DIV_WAIT,
    S_WRITE1, S_WRITE2, S_FETCH_T, S_DONE
  } state_t;

endpackage

>>> sv/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/rpn_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module rpn_div
  import rpn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  div_req_t          req,
  output logic              done,
  output logic [DATA_W-1:0] result
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] mb_r, mb_nxt;
  logic              na_r, na_nxt;
  logic              nb_r, nb_nxt;
  logic              mod_r, mod_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    mb_r  <= mb_nxt;
    na_r  <= na_nxt;
    nb_r  <= nb_nxt;
    mod_r <= mod_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    mb_nxt   = mb_r;
    na_nxt   = na_r;
    nb_nxt   = nb_r;
    mod_nxt  = mod_r;
    shifted  = {rem_r, q_r[DATA_W-1]};
    diff     = shifted - {1'b0, mb_r};
    if (start) begin
      na_nxt   = req.dividend[DATA_W-1];
      nb_nxt   = req.divisor[DATA_W-1];
      mod_nxt  = req.want_mod;
      q_nxt    = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
      mb_nxt   = req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
      end
      q_nxt   = {q_r[DATA_W-2:0], ~diff[DATA_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (mod_r) begin
      result = na_r ? (~rem_r + 1'b1) : rem_r;
    end else begin
      result = (na_r != nb_r) ? (~q_r + 1'b1) : q_r;
    end
  end

  assign done = done_r;

endmodule

>>> sv/rpn_int_bool_stack_calculator_top.sv
// Top level: RPN stack calculator, stack held in one RAM, sequenced controller.
// Each accepted word runs through S_FETCH_A, S_FETCH_B, S_EXEC, S_CALC, S_WRITE1, S_WRITE2, S_FETCH_T and S_DONE.
// div and mod also wait in S_DIV_WAIT for the iterative divider (one quotient bit a cycle).
// A new word is accepted only in S_IDLE, once the previous result is in the output register.
// Reset: synchronous active-low rst_n empties the stack; RAM contents are not cleared.
`timescale 1ns / 1ps
module rpn_int_bool_stack_calculator_top
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = DATA_W + 1;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   depth_r, depth_nxt;
  in_word_t        cmd_r, cmd_nxt;
  entry_t          a_r, a_nxt;
  entry_t          b_r, b_nxt;
  entry_t          res_r, res_nxt;
  logic [2:0]      status_r, status_nxt;
  logic            w1_en_r, w1_en_nxt;
  logic            w2_en_r, w2_en_nxt;
  logic [AW-1:0]   w1_addr_r, w1_addr_nxt;
  logic [AW-1:0]   w2_addr_r, w2_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  entry_t          rd_entry;

  logic            div_start;
  div_req_t        div_req;
  logic            div_done;
  logic [DATA_W-1:0] div_result;

  logic [CW-1:0]   dm1, dm2;
  logic [AW-1:0]   addr_m1, addr_m2, addr_d;
  logic            full, is_empty, one_left;
  logic signed [DATA_W-1:0] av, bv;
  logic [DATA_W-1:0] mul_lo;

  rpn_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  rpn_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .req    (div_req),
    .done   (div_done),
    .result (div_result)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign dm1      = depth_r - CW'(1);
  assign dm2      = depth_r - CW'(2);
  assign addr_m1  = dm1[AW-1:0];
  assign addr_m2  = dm2[AW-1:0];
  assign addr_d   = AW'(depth_r);
  assign full     = (depth_r == CW'(STACK_DEPTH));
  assign is_empty = (depth_r == '0);
  assign one_left = (depth_r == CW'(1));
  assign av       = a_r.value;
  assign bv       = b_r.value;
  assign mul_lo   = DATA_W'(bv * av);
  assign div_req  = '{dividend: b_r.value, divisor: a_r.value,
                      want_mod: (cmd_r.action == ACT_MOD)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    w1_en_r    <= w1_en_nxt;
    w2_en_r    <= w2_en_nxt;
    w1_addr_r  <= w1_addr_nxt;
    w2_addr_r  <= w2_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    w1_en_nxt     = w1_en_r;
    w2_en_nxt     = w2_en_r;
    w1_addr_nxt   = w1_addr_r;
    w2_addr_nxt   = w2_addr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = w1_addr_r;
    ram_wdata     = res_r;
    ram_raddr     = addr_m1;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = S_FETCH_A;
        end
      end
      S_FETCH_A: begin
        ram_raddr = addr_m1;
        state_nxt = S_FETCH_B;
      end
      S_FETCH_B: begin
        a_nxt     = rd_entry;
        ram_raddr = addr_m2;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        b_nxt     = rd_entry;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        status_nxt = ST_OK;
        w1_en_nxt  = 1'b0;
        w2_en_nxt  = 1'b0;
        state_nxt  = S_WRITE1;
        if (cmd_r.action == ACT_PUSH_INT || cmd_r.action == ACT_PUSH_BOOL) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            w1_en_nxt   = 1'b1;
            w1_addr_nxt = addr_d;
            if (cmd_r.action == ACT_PUSH_INT) begin
              res_nxt = '{tag: 1'b0, value: cmd_r.int_operand};
            end else begin
              res_nxt = '{tag: 1'b1, value: DATA_W'(cmd_r.bool_operand)};
            end
            depth_nxt   = depth_r + CW'(1);
          end
        end else if (cmd_r.action == ACT_CLEAR) begin
          depth_nxt = '0;
        end else if (cmd_r.action == ACT_DROP) begin
          if (is_empty) status_nxt = ST_EMPTY;
          else depth_nxt = dm1;
        end else if (cmd_r.action == ACT_DUP) begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            w1_en_nxt   = 1'b1;
            w1_addr_nxt = addr_d;
            res_nxt     = a_r;
            depth_nxt   = depth_r + CW'(1);
          end
        end else if (cmd_r.action == ACT_NOT) begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (!a_r.tag) begin
            status_nxt = ST_NOT_BOOL;
            depth_nxt  = dm1;
          end else begin
            w1_en_nxt   = 1'b1;
            w1_addr_nxt = addr_m1;
            res_nxt     = '{tag: 1'b1, value: a_r.value ^ DATA_W'(1)};
          end
        end else if (cmd_r.action == ACT_PRINT) begin
          if (is_empty) status_nxt = ST_EMPTY;
        end else if (cmd_r.action >= ACT_SWAP && cmd_r.action <= ACT_LE) begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (one_left) begin
            status_nxt = ST_EMPTY;
            depth_nxt  = '0;
          end else if (cmd_r.action == ACT_SWAP) begin
            w1_en_nxt   = 1'b1;
            w1_addr_nxt = addr_m2;
            res_nxt     = a_r;
            w2_en_nxt   = 1'b1;
            w2_addr_nxt = addr_m1;
          end else if (cmd_r.action == ACT_EQ) begin
            w1_en_nxt   = 1'b1;
            w1_addr_nxt = addr_m2;
            res_nxt     = '{tag: 1'b1, value: DATA_W'(a_r == b_r)};
            depth_nxt   = dm1;
          end else if (a_r.tag || b_r.tag) begin
            status_nxt = ST_NOT_INT;
            depth_nxt  = dm2;
          end else if ((cmd_r.action == ACT_DIV || cmd_r.action == ACT_MOD) &&
                       a_r.value == '0) begin
            status_nxt = ST_DIV_ZERO;
            depth_nxt  = dm2;
          end else begin
            w1_en_nxt   = 1'b1;
            w1_addr_nxt = addr_m2;
            depth_nxt   = dm1;
            res_nxt.tag = 1'b1;
            priority case (cmd_r.action)
              ACT_ADD: res_nxt = '{tag: 1'b0, value: b_r.value + a_r.value};
              ACT_SUB: res_nxt = '{tag: 1'b0, value: b_r.value - a_r.value};
              ACT_MUL: res_nxt = '{tag: 1'b0, value: mul_lo};
              ACT_DIV, ACT_MOD: begin
                div_start = 1'b1;
                state_nxt = S_DIV_WAIT;
              end
              ACT_GT: res_nxt.value = DATA_W'(bv > av);
              ACT_LT: res_nxt.value = DATA_W'(bv < av);
              ACT_GE: res_nxt.value = DATA_W'(bv >= av);
              default: res_nxt.value = DATA_W'(bv <= av);
            endcase
          end
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          res_nxt   = '{tag: 1'b0, value: div_result};
          state_nxt = S_WRITE1;
        end
      end
      S_WRITE1: begin
        ram_we    = w1_en_r;
        ram_waddr = w1_addr_r;
        ram_wdata = res_r;
        state_nxt = S_WRITE2;
      end
      S_WRITE2: begin
        ram_we    = w2_en_r;
        ram_waddr = w2_addr_r;
        ram_wdata = b_r;
        state_nxt = S_FETCH_T;
      end
      S_FETCH_T: begin
        ram_raddr = addr_m1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ram_raddr = addr_m1;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.top_valid   = !is_empty;
          out_data_nxt.top_value   = is_empty ? '0 : rd_entry.value;
          out_data_nxt.top_is_bool = is_empty ? 1'b0 : rd_entry.tag;
          out_data_nxt.stack_depth = 7'(depth_r);
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sim/testbench.sv
// Testbench: random and directed command words checked against a behavioral stack predictor.
`timescale 1ns / 1ps
module testbench
  import rpn_pkg::*;
();

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  rpn_int_bool_stack_calculator_top #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  in_word_t  cmd_queue[$];
  out_word_t expected_words[$];
  logic [31:0] stk_val[DEPTH];
  logic        stk_tag[DEPTH];
  int          stk_n = 0;
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_send = 1'b0;
  bit          in_acc = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b, bit want_mod);
    logic [31:0] ma, mb, q, r;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (want_mod) return a[31] ? -r : r;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic out_word_t stack_step(in_word_t w);
    out_word_t o;
    logic [2:0] st;
    logic [31:0] v1, v2, res;
    logic t1, t2;
    st = ST_OK;
    case (w.action)
      ACT_PUSH_INT, ACT_PUSH_BOOL: begin
        if (stk_n >= DEPTH) st = ST_FULL;
        else begin
          stk_val[stk_n] = (w.action == ACT_PUSH_INT) ? w.int_operand : {31'd0, w.bool_operand};
          stk_tag[stk_n] = (w.action == ACT_PUSH_BOOL);
          stk_n++;
        end
      end
      ACT_CLEAR: stk_n = 0;
      ACT_DROP: if (stk_n == 0) st = ST_EMPTY; else stk_n--;
      ACT_DUP: begin
        if (stk_n == 0) st = ST_EMPTY;
        else if (stk_n >= DEPTH) st = ST_FULL;
        else begin
          stk_val[stk_n] = stk_val[stk_n-1];
          stk_tag[stk_n] = stk_tag[stk_n-1];
          stk_n++;
        end
      end
      ACT_NOT: begin
        if (stk_n == 0) st = ST_EMPTY;
        else begin
          stk_n--;
          if (!stk_tag[stk_n]) st = ST_NOT_BOOL;
          else begin
            stk_val[stk_n] = stk_val[stk_n] ^ 32'd1;
            stk_n++;
          end
        end
      end
      ACT_PRINT: if (stk_n == 0) st = ST_EMPTY;
      default: begin
        if (w.action >= ACT_SWAP && w.action <= ACT_LE) begin
          if (stk_n == 0) st = ST_EMPTY;
          else begin
            stk_n--; v1 = stk_val[stk_n]; t1 = stk_tag[stk_n];
            if (stk_n == 0) st = ST_EMPTY;
            else begin
              stk_n--; v2 = stk_val[stk_n]; t2 = stk_tag[stk_n];
              if (w.action == ACT_SWAP) begin
                stk_val[stk_n] = v1; stk_tag[stk_n] = t1;
                stk_val[stk_n+1] = v2; stk_tag[stk_n+1] = t2;
                stk_n += 2;
              end else if (w.action == ACT_EQ) begin
                stk_val[stk_n] = {31'd0, (t1 == t2) && (v1 == v2)};
                stk_tag[stk_n] = 1'b1; stk_n++;
              end else if (t1 || t2) st = ST_NOT_INT;
              else if ((w.action == ACT_DIV || w.action == ACT_MOD) && v1 == 0)
                st = ST_DIV_ZERO;
              else begin
                stk_tag[stk_n] = 1'b0;
                case (w.action)
                  ACT_ADD: res = v2 + v1;
                  ACT_SUB: res = v2 - v1;
                  ACT_MUL: res = v2 * v1;
                  ACT_DIV: res = trunc_div(v2, v1, 1'b0);
                  ACT_MOD: res = trunc_div(v2, v1, 1'b1);
                  default: begin
                    stk_tag[stk_n] = 1'b1;
                    case (w.action)
                      ACT_GT: res = {31'd0, $signed(v2) > $signed(v1)};
                      ACT_LT: res = {31'd0, $signed(v2) < $signed(v1)};
                      ACT_GE: res = {31'd0, $signed(v2) >= $signed(v1)};
                      default: res = {31'd0, $signed(v2) <= $signed(v1)};
                    endcase
                  end
                endcase
                stk_val[stk_n] = res; stk_n++;
              end
            end
          end
        end
      end
    endcase
    o.status = st;
    o.top_valid = (stk_n > 0);
    o.top_value = (stk_n > 0) ? stk_val[stk_n-1] : 32'd0;
    o.top_is_bool = (stk_n > 0) ? stk_tag[stk_n-1] : 1'b0;
    o.stack_depth = stk_n[6:0];
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic in_word_t mk(logic [4:0] a, logic [31:0] i = 0, logic b = 0);
    in_word_t w;
    w.action = a; w.int_operand = i; w.bool_operand = b;
    return w;
  endfunction

  function automatic logic [31:0] rand_int();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return -32'd1;
      3: return $urandom_range(0, 3) - 1;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0 && !hold_send) begin
          in_data <= cmd_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_acc <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_words.push_back(stack_step(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", 32'(out_data.top_value), 32'd0);
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_data.status !== e.status)
            report("status", 32'(out_data.status), 32'(e.status));
          if (out_data.top_valid !== e.top_valid)
            report("top_valid", 32'(out_data.top_valid), 32'(e.top_valid));
          if (out_data.top_value !== e.top_value)
            report("top_value", 32'(out_data.top_value), 32'(e.top_value));
          if (out_data.top_is_bool !== e.top_is_bool)
            report("top_is_bool", 32'(out_data.top_is_bool), 32'(e.top_is_bool));
          if (out_data.stack_depth !== e.stack_depth)
            report("stack_depth", 32'(out_data.stack_depth), 32'(e.stack_depth));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
  endtask

  initial begin
    int n, d;
    logic [4:0] a;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-stack cases, extremes, type errors, divide corners
    cmd_queue.push_back(mk(ACT_DROP));
    cmd_queue.push_back(mk(ACT_PRINT));
    cmd_queue.push_back(mk(ACT_ADD));
    cmd_queue.push_back(mk(ACT_NOT));
    cmd_queue.push_back(mk(ACT_DUP));
    cmd_queue.push_back(mk(5'd31));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'h7fff_ffff));
    cmd_queue.push_back(mk(ACT_SWAP));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'h8000_0000));
    cmd_queue.push_back(mk(ACT_PUSH_INT, -32'd1));
    cmd_queue.push_back(mk(ACT_DIV));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'h8000_0000));
    cmd_queue.push_back(mk(ACT_PUSH_INT, -32'd1));
    cmd_queue.push_back(mk(ACT_MOD));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'd0));
    cmd_queue.push_back(mk(ACT_DIV));
    cmd_queue.push_back(mk(ACT_PUSH_BOOL, 32'd0, 1'b1));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'd1));
    cmd_queue.push_back(mk(ACT_EQ));
    cmd_queue.push_back(mk(ACT_NOT));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'd5));
    cmd_queue.push_back(mk(ACT_NOT));
    cmd_queue.push_back(mk(ACT_PUSH_BOOL, 32'd0, 1'b0));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'd3));
    cmd_queue.push_back(mk(ACT_SUB));
    wait_drained();

    // fill to full, then overflow
    cmd_queue.push_back(mk(ACT_CLEAR));
    for (int i = 0; i < DEPTH; i++) cmd_queue.push_back(mk(ACT_PUSH_INT, $urandom));
    cmd_queue.push_back(mk(ACT_PUSH_INT, 32'd1));
    cmd_queue.push_back(mk(ACT_PUSH_BOOL, 32'd0, 1'b1));
    cmd_queue.push_back(mk(ACT_DUP));
    cmd_queue.push_back(mk(ACT_CLEAR));

    // pause the sender until everything is back
    wait (cmd_queue.size() == 0 && !in_valid);
    hold_send = 1'b1;
    wait (expected_words.size() == 0);
    hold_send = 1'b0;

    d = 0;
    n = 0;
    while (n < 1600) begin
      if (n > 1400) calm = 1'b1;
      if ($urandom_range(0, 99) < 45 || d < 2) begin
        if ($urandom_range(0, 4) == 0) begin
          cmd_queue.push_back(mk(ACT_PUSH_BOOL, $urandom, 1'($urandom_range(0, 1))));
        end else begin
          cmd_queue.push_back(mk(ACT_PUSH_INT, rand_int(), 1'($urandom_range(0, 1))));
        end
        d++;
      end else begin
        if ($urandom_range(0, 9) == 0) a = 5'($urandom_range(0, 31));
        else a = 5'($urandom_range(2, 17));
        cmd_queue.push_back(mk(a, $urandom, 1'($urandom_range(0, 1))));
        if (a == ACT_CLEAR) d = 0;
        else if (a >= ACT_SWAP && a <= ACT_LE && d > 0) d--;
        else if (a == ACT_DROP && d > 0) d--;
        else if (a == ACT_DUP) d++;
      end
      if (d > 50) begin
        cmd_queue.push_back(mk(ACT_CLEAR));
        d = 0;
        n++;
      end
      n++;
      if (cmd_queue.size() > 32) wait (cmd_queue.size() < 8);
    end
    wait_drained();
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
